FILE: hw/rtl/max_subarray_sum_point_update_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the max subarray sum unit.
// ----------------------------------------------------------------------------
`ifndef MAX_SUBARRAY_SUM_POINT_UPDATE_UNIT_MACROS_SVH
`define MAX_SUBARRAY_SUM_POINT_UPDATE_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MSSPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MSSPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/msspu_pkg.sv
// ----------------------------------------------------------------------------
// msspu_pkg
// Types and constants of the max subarray sum segment tree unit.
// ----------------------------------------------------------------------------
package msspu_pkg;

  localparam int unsigned LEAVES = 1024;
  localparam int unsigned IDX_W  = $clog2(LEAVES);
  localparam int unsigned NODES  = 2 * (1 << IDX_W);
  localparam int unsigned NODE_W = IDX_W + 1;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SUM_W  = 42;
  localparam int unsigned TOT_W  = SUM_W + 1;

  typedef struct packed {
    logic signed [TOT_W-1:0] total;
    logic [SUM_W-1:0]        prefix;
    logic [SUM_W-1:0]        suffix;
    logic [SUM_W-1:0]        best;
  } node_t;

  localparam int unsigned NODE_BITS = $bits(node_t);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LEAF  = 5'b00100,
    ST_MERGE = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_e;

endpackage

FILE: hw/rtl/msspu_ram.sv
// ----------------------------------------------------------------------------
// msspu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module msspu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/msspu_merge.sv
// ----------------------------------------------------------------------------
// msspu_merge
// Node arithmetic: builds a leaf from a value or merges two child nodes.
// ----------------------------------------------------------------------------
module msspu_merge import msspu_pkg::*; (
  input  logic                    leaf_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  node_t                   cur_i,
  input  node_t                   sib_i,
  input  logic                    cur_right_i,
  output node_t                   node_o
);

  node_t                   lft;
  node_t                   rgt;
  node_t                   merged;
  node_t                   leaf;
  logic signed [SUM_W+1:0] pre_alt;
  logic signed [SUM_W+1:0] suf_alt;
  logic [SUM_W:0]          cross_sum;
  logic [SUM_W-1:0]        side_best;

  always_comb begin
    lft = cur_right_i ? sib_i : cur_i;
    rgt = cur_right_i ? cur_i : sib_i;

    pre_alt = $signed({lft.total[TOT_W-1], lft.total}) + $signed({2'b00, rgt.prefix});
    suf_alt = $signed({rgt.total[TOT_W-1], rgt.total}) + $signed({2'b00, lft.suffix});
    cross_sum = {1'b0, lft.suffix} + {1'b0, rgt.prefix};
    side_best = (lft.best > rgt.best) ? lft.best : rgt.best;

    merged.total  = lft.total + rgt.total;
    merged.prefix = (pre_alt > $signed({2'b00, lft.prefix})) ? pre_alt[SUM_W-1:0]
                                                             : lft.prefix;
    merged.suffix = (suf_alt > $signed({2'b00, rgt.suffix})) ? suf_alt[SUM_W-1:0]
                                                             : rgt.suffix;
    merged.best   = (cross_sum > {1'b0, side_best}) ? cross_sum[SUM_W-1:0] : side_best;

    // Negative values clamp to zero for the empty subarray.
    leaf.total  = {{(TOT_W-VAL_W){value_i[VAL_W-1]}}, value_i};
    leaf.prefix = value_i[VAL_W-1] ? '0 : {{(SUM_W-VAL_W){1'b0}}, value_i};
    leaf.suffix = leaf.prefix;
    leaf.best   = leaf.prefix;

    node_o = leaf_i ? leaf : merged;
  end

endmodule

FILE: hw/rtl/max_subarray_sum_point_update_unit.sv
// Update sequence: an accepted input writes its leaf, then one merge per tree
//   level runs up to the root (ten levels for 1024 leaves), then the result is registered.
// Occupancy: input is not ready until the current update is done, as the single
//   node RAM port pair and the shared merge unit walk the path to the root; a stalled output keeps it busy.
// Reset: a clearing pass zeroes all 2048 node RAM entries; input is not ready
//   until it completes.
// ----------------------------------------------------------------------------
// max_subarray_sum_point_update_unit
// Segment tree with point updates returning the maximum subarray sum.
// ----------------------------------------------------------------------------
`include "max_subarray_sum_point_update_unit_macros.svh"

module max_subarray_sum_point_update_unit import msspu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [IDX_W-1:0]        index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SUM_W-1:0]        best_sum_o
);

  state_e            state_q, state_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic [NODE_W-1:0] node_q, node_d;
  node_t             cur_q, cur_d;
  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  best_q, best_d;

  logic                 ram_we;
  logic [NODE_W-1:0]    ram_waddr;
  logic [NODE_BITS-1:0] ram_wdata;
  logic [NODE_W-1:0]    ram_raddr;
  logic [NODE_BITS-1:0] ram_rdata;
  node_t                merged;
  logic [NODE_W-1:0]    parent;
  logic                 in_acc;
  logic                 out_free;

  msspu_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  msspu_merge u_merge (
    .leaf_i      (state_q == ST_IDLE),
    .value_i     (value_i),
    .cur_i       (cur_q),
    .sib_i       (node_t'(ram_rdata)),
    .cur_right_i (node_q[0]),
    .node_o      (merged)
  );

  assign parent     = {1'b0, node_q[NODE_W-1:1]};
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_ready_i;
    best_d      = best_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = cur_q;
    ram_raddr   = node_q ^ NODE_W'(1);

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + NODE_W'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cur_d   = merged;
          node_d  = {1'b1, index_i};
          state_d = ST_LEAF;
        end
      end
      ST_LEAF: begin
        // Write the leaf and fetch its sibling.
        ram_we  = 1'b1;
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        // Write the parent and fetch the parent's sibling in the same cycle.
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = merged;
        ram_raddr = parent ^ NODE_W'(1);
        cur_d     = merged;
        node_d    = parent;
        if (parent == NODE_W'(1)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            best_d      = merged.best;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // Hold the root result until the output register frees up.
        if (out_free) begin
          out_valid_d = 1'b1;
          best_d      = cur_q.best;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    cur_q  <= cur_d;
    best_q <= best_d;
  end

  assign out_valid_o = out_valid_q;
  assign best_sum_o  = best_q;

  `MSSPU_ASSERT(a_acc_to_leaf, in_acc |=> (state_q == ST_LEAF) && node_q[NODE_W-1], "no leaf start")
  `MSSPU_ASSERT(a_merge_node, (state_q == ST_MERGE) |-> (node_q > NODE_W'(1)), "merge above root")
  `MSSPU_ASSERT(a_idle_no_write, (state_q == ST_IDLE) |-> !ram_we, "node RAM written while idle")
  `MSSPU_ASSERT(a_no_overwrite, (out_valid_q && !out_ready_i) |=> out_valid_q && (best_q == $past(best_q)), "result overwritten")
  `MSSPU_ASSERT_ALWAYS(a_clear_not_ready, (state_q == ST_CLEAR) |-> !in_ready_o, "ready while clearing")

endmodule
